// ===== rtl/core/mecanum_wheel_mixer_macros.svh =====
// Assertion helpers for the wheel mixer. Clock and reset names are those of the top level.
`ifndef MECANUM_WHEEL_MIXER_MACROS_SVH
`define MECANUM_WHEEL_MIXER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define MWM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mecanum_wheel_mixer: check failed");

// Next-cycle implication, checked out of reset
`define MWM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mecanum_wheel_mixer: check failed");

`endif

// ===== rtl/core/mwm_pkg.sv =====
`default_nettype none

package mwm_pkg;

  localparam int VelW      = 16;
  localparam int SumW      = VelW + 2;   // three-way sum at full precision
  localparam int MagW      = SumW - 1;   // magnitude of a wheel sum
  localparam int FsW       = 12;
  localparam int ProdW     = MagW + FsW; // magnitude times full scale
  localparam int QuotW     = FsW;        // scaled wheel never exceeds full scale
  localparam int NumWheels = 4;

  localparam int WheelFl = 0;
  localparam int WheelFr = 1;
  localparam int WheelRl = 2;
  localparam int WheelRr = 3;

  localparam int QueueDepthDef = 4;

  localparam logic [FsW-1:0] FullScaleReset = 12'd1000;

  localparam logic [1:0] PinsBrake = 2'd0;
  localparam logic [1:0] PinsFwd   = 2'd1;
  localparam logic [1:0] PinsRev   = 2'd2;

  // one wheel as it leaves the front
  typedef struct packed {
    logic [ProdW-1:0] prod;
    logic [QuotW-1:0] mag_lo;
    logic             neg;
  } wheel_t;

  // one queued command
  typedef struct packed {
    wheel_t [NumWheels-1:0] wheel;
    logic [MagW-1:0]        max_mag;
    logic                   norm;
  } entry_t;

  // one divider lane: partial remainder, dividend bits shifting out / quotient bits in
  typedef struct packed {
    logic [MagW-1:0]  rem;
    logic [QuotW-1:0] dq;
    logic [QuotW-1:0] mag_lo;
    logic             neg;
  } lane_t;

  typedef struct packed {
    lane_t [NumWheels-1:0] lane;
    logic [MagW-1:0]       divisor;
    logic                  norm;
  } divst_t;

  function automatic lane_t lane_init(wheel_t w);
    lane_t l;
    l.rem    = w.prod[ProdW-1:QuotW];
    l.dq     = w.prod[QuotW-1:0];
    l.mag_lo = w.mag_lo;
    l.neg    = w.neg;
    return l;
  endfunction

  // one restoring step: bring down a dividend bit, subtract if it fits
  function automatic lane_t div_step(lane_t l, logic [MagW-1:0] d);
    lane_t       r;
    logic [MagW:0] t;
    logic [MagW:0] diff;
    r    = l;
    t    = {l.rem, l.dq[QuotW-1]};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      r.rem = diff[MagW-1:0];
      r.dq  = {l.dq[QuotW-2:0], 1'b1};
    end else begin
      r.rem = t[MagW-1:0];
      r.dq  = {l.dq[QuotW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mecanum_wheel_mixer.sv =====
// Channel   Dir  Handshake                   Payload
// command   in   in_valid_i / in_ready_o     vel_forward_i, vel_sideways_i, vel_rotate_i
// wheels    out  out_valid_o / out_ready_i   <wheel>_duty_o, <wheel>_pins_o (x4)
// config    in   full_scale_we_i             full_scale_wdata_i
//
// One command beat per cycle sustained while out_ready_i takes results; a beat passes the
// front, the queue and the 12-stage divider (one quotient bit a stage) to the output register.
// rst_ni is asynchronous, active low; it empties the pipe and loads full scale 1000.
// A stalled result holds the whole back end; the front keeps taking beats until
// its credits for the queue run out, then drops in_ready_o.
`default_nettype none

`include "mecanum_wheel_mixer_macros.svh"

module mecanum_wheel_mixer
  import mwm_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDef  // 2 or more; 4 or more for full rate
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration
  input  wire logic                   full_scale_we_i,
  input  wire logic [FsW-1:0]         full_scale_wdata_i,
  // command beat
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic signed [VelW-1:0] vel_forward_i,
  input  wire logic signed [VelW-1:0] vel_sideways_i,
  input  wire logic signed [VelW-1:0] vel_rotate_i,
  // wheel beat
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [FsW-1:0]              front_left_duty_o,
  output logic [1:0]                  front_left_pins_o,
  output logic [FsW-1:0]              front_right_duty_o,
  output logic [1:0]                  front_right_pins_o,
  output logic [FsW-1:0]              rear_left_duty_o,
  output logic [1:0]                  rear_left_pins_o,
  output logic [FsW-1:0]              rear_right_duty_o,
  output logic [1:0]                  rear_right_pins_o
);

  // full scale: PWM top and wheel speed limit
  logic [FsW-1:0] full_scale_q;

  // front -> queue -> back
  logic   q_push, q_pop, q_avail;
  entry_t q_in, q_head;

  logic [NumWheels-1:0][QuotW-1:0] duty;
  logic [NumWheels-1:0][1:0]       pins;
  logic [NumWheels-1:0]            wheel_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= FullScaleReset;
    end else if (full_scale_we_i) begin
      full_scale_q <= full_scale_wdata_i;
    end
  end

  // front: mixing sums, magnitudes, products by full scale, largest magnitude
  mwm_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .vel_forward_i  (vel_forward_i),
    .vel_sideways_i (vel_sideways_i),
    .vel_rotate_i   (vel_rotate_i),
    .full_scale_i   (full_scale_q),
    .pop_i          (q_pop),
    .push_o         (q_push),
    .entry_o        (q_in)
  );

  mwm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .pop_i   (q_pop),
    .avail_o (q_avail),
    .head_o  (q_head)
  );

  // back: pipelined divide by the largest magnitude, then PWM and pin drive
  mwm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_avail),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .duty_o       (duty),
    .pins_o       (pins)
  );

  assign front_left_duty_o  = duty[WheelFl];
  assign front_left_pins_o  = pins[WheelFl];
  assign front_right_duty_o = duty[WheelFr];
  assign front_right_pins_o = pins[WheelFr];
  assign rear_left_duty_o   = duty[WheelRl];
  assign rear_left_pins_o   = pins[WheelRl];
  assign rear_right_duty_o  = duty[WheelRr];
  assign rear_right_pins_o  = pins[WheelRr];

  // a wheel brakes exactly when its duty is zero, and never runs past full scale
  always_comb begin
    for (int i = 0; i < NumWheels; i++) begin
      wheel_ok[i] = (pins[i] != 2'd3) &&
                    ((pins[i] == PinsBrake) == (duty[i] == '0)) &&
                    (duty[i] <= full_scale_q);
    end
  end

  `MWM_ASSERT_IMP(a_wheel_legal, out_valid_o, &wheel_ok)
  `MWM_ASSERT_IMP(a_pop_needs_entry, q_pop, q_avail)
  `MWM_ASSERT_NXT(a_push_after_accept_gap, !in_ready_o && !q_pop, !q_push || q_avail || q_pop)

endmodule

`default_nettype wire

// ===== rtl/core/mwm_front.sv =====
`default_nettype none

module mwm_front
  import mwm_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic signed [VelW-1:0] vel_forward_i,
  input  wire logic signed [VelW-1:0] vel_sideways_i,
  input  wire logic signed [VelW-1:0] vel_rotate_i,
  input  wire logic [FsW-1:0]         full_scale_i,
  input  wire logic                   pop_i,
  output logic                        push_o,
  output entry_t                      entry_o
);

  localparam int CntW = $clog2(QueueDepth + 1);

  // beats accepted and not yet popped from the queue; bounds queue use
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;

  logic signed [SumW-1:0] f, s, r;
  logic signed [SumW-1:0] sum_d [NumWheels];
  logic signed [SumW-1:0] sum_q [NumWheels];
  logic                   va_q, vb_q;

  logic [MagW-1:0] mag [NumWheels];
  logic [SumW-1:0] absv [NumWheels];
  logic [MagW-1:0] m01, m23, mx;
  entry_t          entry_d, entry_q;

  assign in_ready_o = (cnt_q < CntW'(QueueDepth));
  assign accept     = in_valid_i & in_ready_o;
  assign cnt_d      = cnt_q + CntW'(accept) - CntW'(pop_i);

  assign f = {{(SumW-VelW){vel_forward_i[VelW-1]}}, vel_forward_i};
  assign s = {{(SumW-VelW){vel_sideways_i[VelW-1]}}, vel_sideways_i};
  assign r = {{(SumW-VelW){vel_rotate_i[VelW-1]}}, vel_rotate_i};

  always_comb begin
    sum_d[WheelFl] = f - s - r;
    sum_d[WheelFr] = f + s + r;
    sum_d[WheelRl] = f + s - r;
    sum_d[WheelRr] = f - s + r;
  end

  // stage B: magnitudes, scaled products, largest magnitude
  always_comb begin
    for (int i = 0; i < NumWheels; i++) begin
      absv[i] = sum_q[i][SumW-1] ? (-sum_q[i]) : sum_q[i];
      mag[i]  = absv[i][MagW-1:0];
      entry_d.wheel[i].prod   = ProdW'(mag[i]) * ProdW'(full_scale_i);
      entry_d.wheel[i].mag_lo = mag[i][QuotW-1:0];
      entry_d.wheel[i].neg    = sum_q[i][SumW-1];
    end
    m01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
    m23 = (mag[2] > mag[3]) ? mag[2] : mag[3];
    mx  = (m01 > m23) ? m01 : m23;
    entry_d.max_mag = mx;
    entry_d.norm    = (mx > MagW'(full_scale_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      va_q  <= accept;
      vb_q  <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < NumWheels; i++) sum_q[i] <= sum_d[i];
    end
    if (va_q) begin
      entry_q <= entry_d;
    end
  end

  assign push_o  = vb_q;
  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== rtl/core/mwm_queue.sv =====
`default_nettype none

module mwm_queue
  import mwm_pkg::*;
#(
  parameter int Depth = QueueDepthDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t entry_i,
  input  wire logic   pop_i,
  output logic        avail_o,
  output entry_t      head_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  entry_t          slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  // room is guaranteed by the front's credit count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= entry_i;
  end

  assign avail_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== rtl/core/mwm_back.sv =====
`default_nettype none

module mwm_back
  import mwm_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        head_valid_i,
  input  wire entry_t                      head_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [NumWheels-1:0][QuotW-1:0]  duty_o,
  output logic [NumWheels-1:0][1:0]        pins_o
);

  localparam int Stages = QuotW;  // one quotient bit per stage

  divst_t              st_d [Stages];
  divst_t              st_q [Stages];
  logic [Stages-1:0]   vld_q;
  logic                en;
  logic                out_valid_q;
  logic [NumWheels-1:0][QuotW-1:0] duty_d, duty_q;
  logic [NumWheels-1:0][1:0]       pins_d, pins_q;
  logic [QuotW-1:0]    spd [NumWheels];

  // whole back end moves together; the output register frees when taken
  assign en    = !out_valid_q | out_ready_i;
  assign pop_o = head_valid_i & en;

  always_comb begin
    st_d[0].divisor = head_i.max_mag;
    st_d[0].norm    = head_i.norm;
    for (int i = 0; i < NumWheels; i++) begin
      st_d[0].lane[i] = div_step(lane_init(head_i.wheel[i]), head_i.max_mag);
    end
    for (int k = 1; k < Stages; k++) begin
      st_d[k] = st_q[k-1];
      for (int i = 0; i < NumWheels; i++) begin
        st_d[k].lane[i] = div_step(st_q[k-1].lane[i], st_q[k-1].divisor);
      end
    end
  end

  // quotient when scaled, plain magnitude otherwise
  always_comb begin
    for (int i = 0; i < NumWheels; i++) begin
      spd[i] = st_q[Stages-1].norm ? st_q[Stages-1].lane[i].dq
                                   : st_q[Stages-1].lane[i].mag_lo;
      duty_d[i] = spd[i];
      if (spd[i] == '0) begin
        pins_d[i] = PinsBrake;
      end else if (st_q[Stages-1].lane[i].neg) begin
        pins_d[i] = PinsRev;
      end else begin
        pins_d[i] = PinsFwd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[Stages-2:0], head_valid_i};
      out_valid_q <= vld_q[Stages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < Stages; k++) st_q[k] <= st_d[k];
      duty_q <= duty_d;
      pins_q <= pins_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;
  assign pins_o      = pins_q;

endmodule

`default_nettype wire
